### design/hblank_vram_dma_engine_defines.svh
// assertion macros for the dma engine core
`ifndef HBLANK_VRAM_DMA_ENGINE_DEFINES_SVH
`define HBLANK_VRAM_DMA_ENGINE_DEFINES_SVH

// same-cycle implication, held off during reset
`define HVDMA_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hvdma assertion failed");

// next-cycle implication, held off during reset
`define HVDMA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hvdma assertion failed");

`endif

### design/hvdma_pkg.sv
`default_nettype none

package hvdma_pkg;

   // item kinds
   localparam logic [1:0] KIND_TICK  = 2'd0;
   localparam logic [1:0] KIND_READ  = 2'd1;
   localparam logic [1:0] KIND_WRITE = 2'd2;

   // register indexes
   localparam logic [2:0] REG_SRC_HI = 3'd0;
   localparam logic [2:0] REG_SRC_LO = 3'd1;
   localparam logic [2:0] REG_DST_HI = 3'd2;
   localparam logic [2:0] REG_DST_LO = 3'd3;
   localparam logic [2:0] REG_CTRL   = 3'd4;

   // memory operations
   localparam logic [1:0] MEM_NONE  = 2'd0;
   localparam logic [1:0] MEM_READ  = 2'd1;
   localparam logic [1:0] MEM_WRITE = 2'd2;

   // csr address width and the single csr index
   localparam int unsigned CsrAddrWidth = 3;
   localparam logic CSR_ENHANCED = 1'b0;

   typedef enum logic [5:0] {
      PH_IDLE        = 6'b000001,
      PH_TERM        = 6'b000010,
      PH_READ        = 6'b000100,
      PH_WRITE       = 6'b001000,
      PH_WAIT_HB     = 6'b010000,
      PH_WAIT_NOT_HB = 6'b100000
   } phase_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [2:0] reg_index;
      logic [7:0] write_value;
      logic       in_hblank;
      logic [7:0] mem_data;
   } item_type;

   typedef struct packed {
      logic [7:0]  reg_read_data;
      logic [1:0]  mem_op;
      logic [15:0] mem_address;
      logic [7:0]  mem_write_data;
      logic [12:0] gdma_cycles_left;
   } result_type;

endpackage

`default_nettype wire

### design/hvdma_csr.sv
`default_nettype none

module hvdma_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [hvdma_pkg::CsrAddrWidth-1:0] paddr,
   input  wire logic [31:0]                       pwdata,
   output logic [31:0]                            prdata,
   output logic                                   pready,
   output logic                                   enhanced_mode
);
   import hvdma_pkg::*;

   logic enhanced_ff;
   logic enhanced_in;
   logic wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;

   always_comb begin
      enhanced_in = enhanced_ff;
      if (wr_en && paddr[CsrAddrWidth-1] == CSR_ENHANCED) begin
         enhanced_in = pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enhanced_ff <= 1'b1;
      end else begin
         enhanced_ff <= enhanced_in;
      end
   end

   assign prdata = (paddr[CsrAddrWidth-1] == CSR_ENHANCED) ? {31'd0, enhanced_ff} : 32'd0;
   assign enhanced_mode = enhanced_ff;

endmodule

`default_nettype wire

### design/hvdma_core.sv
`default_nettype none
`include "hblank_vram_dma_engine_defines.svh"

module hvdma_core (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  advance,
   input  wire hvdma_pkg::item_type   item,
   input  wire logic                  enhanced_mode,
   output hvdma_pkg::result_type      result
);
   import hvdma_pkg::*;

   logic [7:0]  src_hi_ff, src_hi_in;
   logic [7:0]  src_lo_ff, src_lo_in;
   logic [7:0]  dst_hi_ff, dst_hi_in;
   logic [7:0]  dst_lo_ff, dst_lo_in;
   logic [11:0] bytes_left_ff, bytes_left_in;
   logic        hblank_xfer_ff, hblank_xfer_in;
   logic [4:0]  block_left_ff, block_left_in;
   phase_type   phase_ff, phase_in;
   logic [15:0] src_ptr_ff, src_ptr_in;
   logic [15:0] dst_ptr_ff, dst_ptr_in;

   logic [7:0]  blocks;
   logic [7:0]  start_blocks;
   logic [11:0] bytes_after;
   logic [15:0] dst_next;
   logic [4:0]  block_after;

   always_comb begin
      src_hi_in      = src_hi_ff;
      src_lo_in      = src_lo_ff;
      dst_hi_in      = dst_hi_ff;
      dst_lo_in      = dst_lo_ff;
      bytes_left_in  = bytes_left_ff;
      hblank_xfer_in = hblank_xfer_ff;
      block_left_in  = block_left_ff;
      phase_in       = phase_ff;
      src_ptr_in     = src_ptr_ff;
      dst_ptr_in     = dst_ptr_ff;
      result         = '0;

      blocks       = bytes_left_ff[11:4] - 8'd1;
      start_blocks = {1'b0, item.write_value[6:0]} + 8'd1;
      bytes_after  = bytes_left_ff - 12'd1;
      dst_next     = dst_ptr_ff + 16'd1;
      block_after  = block_left_ff - 5'd1;

      case (item.kind)
         KIND_TICK: begin
            case (phase_ff)
               PH_READ: begin
                  result.mem_op      = MEM_READ;
                  result.mem_address = src_ptr_ff;
                  src_ptr_in         = src_ptr_ff + 16'd1;
                  phase_in           = PH_WRITE;
               end
               PH_WRITE: begin
                  if (bytes_left_ff == 12'd0) begin
                     phase_in = PH_IDLE;
                  end else begin
                     result.mem_op         = MEM_WRITE;
                     result.mem_address    = dst_ptr_ff;
                     result.mem_write_data = item.mem_data;
                     dst_ptr_in            = dst_next;
                     bytes_left_in         = bytes_after;
                     // address registers follow the live pointers
                     src_hi_in             = src_ptr_ff[15:8];
                     src_lo_in             = src_ptr_ff[7:0];
                     dst_hi_in             = dst_next[15:8];
                     dst_lo_in             = dst_next[7:0];
                     if (hblank_xfer_ff) begin
                        block_left_in = block_after;
                     end
                     if (hblank_xfer_ff && block_after == 5'd0 && bytes_after != 12'd0) begin
                        phase_in = PH_WAIT_NOT_HB;
                     end else if (bytes_after == 12'd0) begin
                        phase_in = PH_IDLE;
                     end else begin
                        phase_in = PH_READ;
                     end
                  end
               end
               PH_WAIT_HB: begin
                  if (item.in_hblank) begin
                     phase_in      = PH_READ;
                     block_left_in = 5'd16;
                  end
               end
               PH_WAIT_NOT_HB: begin
                  if (!item.in_hblank) begin
                     phase_in = PH_WAIT_HB;
                  end
               end
               default: begin
               end
            endcase
         end
         KIND_READ: begin
            if (!enhanced_mode || item.reg_index != REG_CTRL) begin
               result.reg_read_data = 8'hFF;
            end else begin
               case (phase_ff)
                  PH_IDLE: result.reg_read_data = 8'hFF;
                  PH_TERM: result.reg_read_data = blocks | 8'h80;
                  default: result.reg_read_data = blocks;
               endcase
            end
         end
         KIND_WRITE: begin
            if (enhanced_mode) begin
               case (item.reg_index)
                  REG_SRC_HI: src_hi_in = item.write_value;
                  REG_SRC_LO: src_lo_in = item.write_value;
                  REG_DST_HI: dst_hi_in = item.write_value;
                  REG_DST_LO: dst_lo_in = item.write_value;
                  REG_CTRL: begin
                     if ((phase_ff inside {PH_IDLE, PH_TERM}) ||
                         (hblank_xfer_ff && item.write_value[7])) begin
                        bytes_left_in  = {start_blocks, 4'd0};
                        hblank_xfer_in = item.write_value[7];
                        src_ptr_in     = {src_hi_ff, src_lo_ff[7:4], 4'd0};
                        dst_ptr_in     = {3'b100, dst_hi_ff[4:0], dst_lo_ff[7:4], 4'd0};
                        phase_in       = item.write_value[7] ? PH_WAIT_HB : PH_READ;
                     end else if (hblank_xfer_ff) begin
                        phase_in = PH_TERM;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         default: begin
         end
      endcase

      result.gdma_cycles_left = (hblank_xfer_in || bytes_left_in == 12'd0) ? 13'd0
                                : {bytes_left_in, 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_hi_ff      <= 8'd0;
         src_lo_ff      <= 8'd0;
         dst_hi_ff      <= 8'd0;
         dst_lo_ff      <= 8'd0;
         bytes_left_ff  <= 12'd0;
         hblank_xfer_ff <= 1'b0;
         block_left_ff  <= 5'd0;
         phase_ff       <= PH_IDLE;
         src_ptr_ff     <= 16'd0;
         dst_ptr_ff     <= 16'd0;
      end else if (advance) begin
         src_hi_ff      <= src_hi_in;
         src_lo_ff      <= src_lo_in;
         dst_hi_ff      <= dst_hi_in;
         dst_lo_ff      <= dst_lo_in;
         bytes_left_ff  <= bytes_left_in;
         hblank_xfer_ff <= hblank_xfer_in;
         block_left_ff  <= block_left_in;
         phase_ff       <= phase_in;
         src_ptr_ff     <= src_ptr_in;
         dst_ptr_ff     <= dst_ptr_in;
      end
   end

   // a read request is only ever pending with bytes still to move
   `HVDMA_ASSERT_IMPLY(a_read_has_bytes, clock, reset, phase_ff == PH_READ, bytes_left_ff != 12'd0)
   // an hblank block never holds more than sixteen bytes
   `HVDMA_ASSERT_IMPLY(a_block_bound, clock, reset, 1'b1, block_left_ff <= 5'd16)
   // a byte write is never followed by another write without a read
   `HVDMA_ASSERT_NEXT(a_write_leaves, clock, reset,
      advance && item.kind == KIND_TICK && phase_ff == PH_WRITE, phase_ff != PH_WRITE)

endmodule

`default_nettype wire

### design/hblank_vram_dma_engine.sv
// channel   direction   handshake               payload
// req       in          req_valid / req_ready   kind, reg_index, write_value, in_hblank, mem_data
// rsp       out         rsp_valid / rsp_ready   reg_read_data, mem_op, mem_address, ...
// csr       in/out      psel, penable, pready   paddr, pwdata, prdata (enhanced_mode)
//
// one item per cycle sustained while rsp_ready is high; an item passes from req to rsp
// through the input register, then the engine step into the result register
// the engine state updates when an item moves from the input to the result register
// req_ready stays high while the result register is empty or being drained
// synchronous active-high reset clears the engine to idle with enhanced_mode set
`default_nettype none

module hblank_vram_dma_engine (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [1:0]                        req_kind,
   input  wire logic [2:0]                        req_reg_index,
   input  wire logic [7:0]                        req_write_value,
   input  wire logic                              req_in_hblank,
   input  wire logic [7:0]                        req_mem_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [7:0]                             rsp_reg_read_data,
   output logic [1:0]                             rsp_mem_op,
   output logic [15:0]                            rsp_mem_address,
   output logic [7:0]                             rsp_mem_write_data,
   output logic [12:0]                            rsp_gdma_cycles_left,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [hvdma_pkg::CsrAddrWidth-1:0] paddr,
   input  wire logic [31:0]                       pwdata,
   output logic [31:0]                            prdata,
   output logic                                   pready
);
   import hvdma_pkg::*;

   logic       in_valid_ff, in_valid_in;
   item_type   item_ff;
   logic       out_valid_ff, out_valid_in;
   result_type result_ff;
   result_type step_result;
   logic       advance;
   logic       enhanced_mode;

   hvdma_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready),
      .enhanced_mode (enhanced_mode)
   );

   hvdma_core u_core (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .item          (item_ff),
      .enhanced_mode (enhanced_mode),
      .result        (step_result)
   );

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in  = in_valid_ff;
      out_valid_in = out_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff.kind        <= req_kind;
         item_ff.reg_index   <= req_reg_index;
         item_ff.write_value <= req_write_value;
         item_ff.in_hblank   <= req_in_hblank;
         item_ff.mem_data    <= req_mem_data;
      end
      if (advance) begin
         result_ff <= step_result;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_reg_read_data    = result_ff.reg_read_data;
   assign rsp_mem_op           = result_ff.mem_op;
   assign rsp_mem_address      = result_ff.mem_address;
   assign rsp_mem_write_data   = result_ff.mem_write_data;
   assign rsp_gdma_cycles_left = result_ff.gdma_cycles_left;

endmodule

`default_nettype wire
